/* rtl/core/fesg_pkg.sv */
// shared constants, fixed-point helpers and types for the element shape gradient block
package fesg_pkg;

  localparam int FRAC_BITS = 16;

  // Q.30 factors: 1 and 1 +- 1/sqrt3
  localparam logic [63:0] ONE30 = 64'd1 << 30;
  localparam logic [63:0] GPT30 = 64'd619925131;
  localparam logic [63:0] FP30  = ONE30 + GPT30;
  localparam logic [63:0] FM30  = ONE30 - GPT30;

  function automatic logic [63:0] rnd_shift(input logic [63:0] v, input int s);
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
    return rnd_shift(a * b, 30);
  endfunction

  function automatic logic [16:0] sv_sat(input logic [63:0] v);
    return (v > 64'h1FFFF) ? 17'h1FFFF : v[16:0];
  endfunction

  // products of two factors, rounded to Q.30
  localparam logic [63:0] E_PP = mul30(FP30, FP30);
  localparam logic [63:0] E_PM = mul30(FP30, FM30);
  localparam logic [63:0] E_MM = mul30(FM30, FM30);

  // shape values: hex by (mismatches on x/y, mismatch on z), quad by mismatches
  localparam logic [16:0] SV3_00 = sv_sat(rnd_shift(E_PP * FP30, 63 - FRAC_BITS));
  localparam logic [16:0] SV3_01 = sv_sat(rnd_shift(E_PP * FM30, 63 - FRAC_BITS));
  localparam logic [16:0] SV3_10 = sv_sat(rnd_shift(E_PM * FP30, 63 - FRAC_BITS));
  localparam logic [16:0] SV3_11 = sv_sat(rnd_shift(E_PM * FM30, 63 - FRAC_BITS));
  localparam logic [16:0] SV3_20 = sv_sat(rnd_shift(E_MM * FP30, 63 - FRAC_BITS));
  localparam logic [16:0] SV3_21 = sv_sat(rnd_shift(E_MM * FM30, 63 - FRAC_BITS));
  localparam logic [16:0] SV3_C  = sv_sat(rnd_shift(ONE30 * ONE30, 63 - FRAC_BITS));
  localparam logic [16:0] SV2_0  = sv_sat(rnd_shift(FP30 * FP30, 62 - FRAC_BITS));
  localparam logic [16:0] SV2_1  = sv_sat(rnd_shift(FP30 * FM30, 62 - FRAC_BITS));
  localparam logic [16:0] SV2_2  = sv_sat(rnd_shift(FM30 * FM30, 62 - FRAC_BITS));

  // alignment shifts of numerator and denominator for the gradient quotient
  localparam int NSH2 = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
  localparam int DSH2 = (FRAC_BITS >= 15) ? 0 : 15 - FRAC_BITS;
  localparam int NSH3 = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DSH3 = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

  localparam int H_W   = 24;
  localparam int E_W   = 32;
  localparam int NUM_W = E_W + NSH2;
  localparam int DEN_W = H_W + DSH3;
  localparam int QB    = 34;
  localparam int ITERS = QB / 2;
  localparam int CNT_W = $clog2(ITERS + 1);
  localparam int N_W0  = (NUM_W + 2 > DEN_W + 2) ? NUM_W + 2 : DEN_W + 2;
  localparam int N_W   = (N_W0 > QB + 1) ? N_W0 : QB + 1;
  localparam int D_W   = DEN_W + 1;
  localparam int Q_W   = 32;
  localparam logic [Q_W-1:0] SAT_MAG = 32'h8000_0000;
  localparam logic [Q_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam int DET_W = 48;

  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] DIMS_HEX   = 2'd3;
  localparam logic [3:0] WEIGHT_ONE = 4'd1;
  localparam logic [3:0] WEIGHT_CTR = 4'd8;

  typedef enum logic {
    CFG_DIMS    = 1'b0,
    CFG_REDUCED = 1'b1
  } fesg_cfg_idx_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_LOAD,
    FR_WAIT,
    FR_PUSH
  } fesg_front_state_e;

  // one classified element handed from front to back
  typedef struct packed {
    logic                        three;
    logic                        centre;
    logic                        singular;
    logic [DET_W-1:0]            det;
    logic [2:0][2:0][Q_W-1:0]    quo;
  } fesg_rec_t;

  typedef struct packed {
    logic [2:0]         quad;
    logic [2:0]         node;
    logic [16:0]        shape;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
    logic [DET_W-1:0]   det;
    logic [3:0]         weight;
    logic               singular;
    logic               last;
  } fesg_res_t;

endpackage

/* rtl/core/fesg_div.sv */
// radix-4 restoring divider lane for rounded, clipped gradient magnitudes
module fesg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fesg_pkg::NUM_W-1:0]    num_i,
  input  logic [fesg_pkg::DEN_W-1:0]    den_i,
  output logic                          done_o,
  output logic [fesg_pkg::Q_W-1:0]      quo_o
);
  import fesg_pkg::*;

  logic [N_W-1:0]   n_q;
  logic [D_W-1:0]   d_q;
  logic [D_W-1:0]   r_q, r_c;
  logic [QB-1:0]    nlo_q, nlo_c;
  logic [QB-1:0]    q_q, q_c;
  logic [CNT_W-1:0] cnt_q;
  logic             load_q, run_q, done_q, ovf_q;
  logic [D_W:0]     t_c;

  always_comb begin
    r_c   = r_q;
    nlo_c = nlo_q;
    q_c   = q_q;
    t_c   = '0;
    for (int i = 0; i < 2; i++) begin
      t_c   = {r_c, nlo_c[QB-1]};
      nlo_c = nlo_c << 1;
      if (t_c >= {1'b0, d_q}) begin
        r_c = D_W'(t_c - {1'b0, d_q});
        q_c = {q_c[QB-2:0], 1'b1};
      end else begin
        r_c = t_c[D_W-1:0];
        q_c = {q_c[QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      load_q <= start_i;
      if (load_q) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(ITERS);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // rounding: (2*num + den) / (2*den)
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= N_W'({num_i, 1'b0}) + N_W'(den_i);
      d_q <= {den_i, 1'b0};
    end
    if (load_q) begin
      ovf_q <= (n_q >> QB) >= N_W'(d_q);
      r_q   <= D_W'(n_q >> QB);
      nlo_q <= n_q[QB-1:0];
      q_q   <= '0;
    end else if (run_q) begin
      r_q   <= r_c;
      nlo_q <= nlo_c;
      q_q   <= q_c;
    end
  end

  assign done_o = done_q;
  assign quo_o  = (ovf_q || (q_q > QB'(SAT_MAG))) ? SAT_MAG : q_q[Q_W-1:0];

endmodule

/* rtl/core/fesg_front.sv */
// front end: takes an element, forms the determinant and the gradient quotients
module fesg_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        three_i,
  input  logic                        centre_i,
  input  logic [fesg_pkg::H_W-1:0]    size_x_i,
  input  logic [fesg_pkg::H_W-1:0]    size_y_i,
  input  logic [fesg_pkg::H_W-1:0]    size_z_i,
  input  logic                        full_i,
  output logic                        busy_o,
  output logic                        push_o,
  output fesg_pkg::fesg_rec_t         rec_o
);
  import fesg_pkg::*;

  fesg_front_state_e         state_q, state_d;
  logic [H_W-1:0]            h_q [3];
  logic                      three_q, centre_q;
  logic [1:0]                idx_q;
  logic [2:0][2:0][Q_W-1:0]  quo_q;
  logic [2*H_W-1:0]          p_q;
  logic [2*H_W+11:0]         hi_q, lo_q;
  logic [DET_W-1:0]          det_q;
  logic [E_W-1:0]            e_c;
  logic [NUM_W-1:0]          num_c;
  logic [DEN_W-1:0]          den_c [3];
  logic [2:0]                lane_done;
  logic [Q_W-1:0]            lane_quo [3];
  logic                      lane_start;
  logic                      all_done;

  assign all_done = &lane_done;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_IDLE: if (start_i) state_d = FR_LOAD;
      FR_LOAD: state_d = FR_WAIT;
      FR_WAIT: begin
        if (all_done) state_d = (idx_q == 2'd2) ? FR_PUSH : FR_LOAD;
      end
      FR_PUSH: if (!full_i) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    busy_o     = (state_q != FR_IDLE);
    lane_start = (state_q == FR_LOAD);
    push_o     = (state_q == FR_PUSH) && !full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= FR_IDLE;
    else         state_q <= state_d;
  end

  // factor (quad) or factor product (hex) for the selected quotient slot
  always_comb begin
    if (centre_q) begin
      e_c = E_W'(ONE30);
    end else if (three_q) begin
      case (idx_q)
        2'd0:    e_c = E_W'(E_PP);
        2'd1:    e_c = E_W'(E_PM);
        default: e_c = E_W'(E_MM);
      endcase
    end else begin
      case (idx_q)
        2'd0:    e_c = E_W'(FP30);
        default: e_c = E_W'(FM30);
      endcase
    end
    num_c = three_q ? (NUM_W'(e_c) << NSH3) : (NUM_W'(e_c) << NSH2);
    for (int k = 0; k < 3; k++) begin
      den_c[k] = three_q ? (DEN_W'(h_q[k]) << DSH3) : (DEN_W'(h_q[k]) << DSH2);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    fesg_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (lane_start),
      .num_i   (num_c),
      .den_i   (den_c[k]),
      .done_o  (lane_done[k]),
      .quo_o   (lane_quo[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FR_IDLE && start_i) begin
      h_q[0]   <= size_x_i;
      h_q[1]   <= size_y_i;
      h_q[2]   <= size_z_i;
      three_q  <= three_i;
      centre_q <= centre_i;
      idx_q    <= 2'd0;
    end else if (state_q == FR_WAIT && all_done) begin
      for (int k = 0; k < 3; k++) quo_q[k][idx_q] <= lane_quo[k];
      idx_q <= idx_q + 2'd1;
    end
    // determinant pipeline, settled long before the push
    p_q   <= h_q[0] * h_q[1];
    hi_q  <= p_q * h_q[2][23:12];
    lo_q  <= p_q * h_q[2][11:0];
    det_q <= three_q ? DET_W'((61'(hi_q) + 61'd16384 + 61'(lo_q >> 12)) >> 15)
                     : DET_W'((49'(p_q) + 49'd512) >> 10);
  end

  always_comb begin
    rec_o.three    = three_q;
    rec_o.centre   = centre_q;
    rec_o.singular = (det_q == '0);
    rec_o.det      = det_q;
    rec_o.quo      = quo_q;
  end

endmodule

/* rtl/core/fesg_fifo.sv */
// short queue of classified elements between front and back
module fesg_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  fesg_pkg::fesg_rec_t   data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output fesg_pkg::fesg_rec_t   data_o
);
  import fesg_pkg::*;

  fesg_rec_t         mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [FCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == FCNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

/* rtl/core/fesg_back.sv */
// back end: walks points and nodes, one registered result per cycle while it holds an element
module fesg_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  fesg_pkg::fesg_rec_t   rec_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  output fesg_pkg::fesg_res_t   res_o
);
  import fesg_pkg::*;

  fesg_rec_t   rec_q;
  logic        active_q;
  logic [2:0]  pt_q, nd_q;
  logic [2:0]  pt_max, nd_max;
  logic        at_end;
  logic        s0, s1, s2, m0, m1, m2;
  logic [1:0]  mxy;
  logic [1:0]  ex [3];
  logic        sgn [3];
  logic [Q_W-1:0] mag;
  logic [31:0] g [3];
  fesg_res_t   res_c, res_q;
  logic        valid_q;

  assign pt_max = rec_q.centre ? 3'd0 : (rec_q.three ? 3'd7 : 3'd3);
  assign nd_max = rec_q.three ? 3'd7 : 3'd3;
  assign at_end = active_q && (pt_q == pt_max) && (nd_q == nd_max);
  assign pop_o  = !empty_i && (!active_q || at_end);

  always_comb begin
    s0 = nd_q[1] ^ nd_q[0];
    s1 = nd_q[1];
    s2 = nd_q[2];
    // a mismatch picks the 1 - 1/sqrt3 factor
    m0 = !rec_q.centre && (s0 != pt_q[0]);
    m1 = !rec_q.centre && (s1 != pt_q[1]);
    m2 = !rec_q.centre && (s2 != pt_q[2]);
    mxy = {1'b0, m0} + {1'b0, m1};
    sgn[0] = s0;
    sgn[1] = s1;
    sgn[2] = s2;
    if (rec_q.three) begin
      ex[0] = {1'b0, m1} + {1'b0, m2};
      ex[1] = {1'b0, m0} + {1'b0, m2};
      ex[2] = mxy;
    end else begin
      ex[0] = {1'b0, m1};
      ex[1] = {1'b0, m0};
      ex[2] = 2'd0;
    end

    res_c.shape = SV2_2;
    if (rec_q.centre) begin
      res_c.shape = SV3_C;
    end else if (rec_q.three) begin
      case ({mxy, m2})
        3'b000:  res_c.shape = SV3_00;
        3'b001:  res_c.shape = SV3_01;
        3'b010:  res_c.shape = SV3_10;
        3'b011:  res_c.shape = SV3_11;
        3'b100:  res_c.shape = SV3_20;
        default: res_c.shape = SV3_21;
      endcase
    end else begin
      case (mxy)
        2'd0:    res_c.shape = SV2_0;
        2'd1:    res_c.shape = SV2_1;
        default: res_c.shape = SV2_2;
      endcase
    end

    mag = '0;
    for (int k = 0; k < 3; k++) begin
      mag = rec_q.quo[k][ex[k]];
      if (rec_q.singular || (k == 2 && !rec_q.three)) g[k] = '0;
      else if (!sgn[k]) g[k] = 32'd0 - mag;
      else              g[k] = (mag == SAT_MAG) ? POS_MAX : mag;
    end

    res_c.quad     = rec_q.centre ? 3'd0 : pt_q;
    res_c.node     = nd_q;
    res_c.gx       = g[0];
    res_c.gy       = g[1];
    res_c.gz       = g[2];
    res_c.det      = rec_q.det;
    res_c.weight   = rec_q.centre ? WEIGHT_CTR : WEIGHT_ONE;
    res_c.singular = rec_q.singular;
    res_c.last     = at_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      pt_q     <= '0;
      nd_q     <= '0;
    end else begin
      valid_q <= active_q;
      if (pop_o) begin
        active_q <= 1'b1;
        pt_q     <= '0;
        nd_q     <= '0;
      end else if (at_end) begin
        active_q <= 1'b0;
      end else if (active_q) begin
        if (nd_q == nd_max) begin
          nd_q <= '0;
          pt_q <= pt_q + 3'd1;
        end else begin
          nd_q <= nd_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= rec_i;
    res_q <= res_c;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/core/fem_element_shape_gradients.sv */
// top level: shape values and global gradients of an axis-aligned quad or hex element
// order: the first result beat follows the divider passes and the queue, and comes later
// while the back still emits an earlier element; then one beat per cycle to the element's last
// intake: the front takes a new element only when idle, after three divider passes and a push;
// a full hex holds the back longer than that, so hexes go at the pace of the back
// reset: dims returns to 3, reduced integration off, queue empty; results cannot be stalled
module fem_element_shape_gradients (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [23:0]         elem_size_x_i,
  input  logic [23:0]         elem_size_y_i,
  input  logic [23:0]         elem_size_z_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [1:0]          cfg_data_i,
  output logic                res_valid_o,
  output logic [2:0]          quad_index_o,
  output logic [2:0]          node_index_o,
  output logic [16:0]         shape_value_o,
  output logic signed [31:0]  grad_x_o,
  output logic signed [31:0]  grad_y_o,
  output logic signed [31:0]  grad_z_o,
  output logic [47:0]         jacobian_det_o,
  output logic [3:0]          weight_o,
  output logic                singular_o,
  output logic                last_o
);
  import fesg_pkg::*;

  logic [1:0] dims_q;
  logic       red_q;
  logic       three, centre;
  logic       push, full, pop, empty;
  fesg_rec_t  rec_in, rec_out;
  fesg_res_t  res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIMS_HEX;
      red_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (fesg_cfg_idx_e'(cfg_index_i))
        CFG_DIMS:    dims_q <= cfg_data_i;
        CFG_REDUCED: red_q  <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  assign three  = (dims_q == DIMS_HEX);
  assign centre = three && red_q;

  fesg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .three_i  (three),
    .centre_i (centre),
    .size_x_i (elem_size_x_i),
    .size_y_i (elem_size_y_i),
    .size_z_i (elem_size_z_i),
    .full_i   (full),
    .busy_o   (busy_o),
    .push_o   (push),
    .rec_o    (rec_in)
  );

  fesg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (rec_out)
  );

  fesg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res)
  );

  assign quad_index_o   = res.quad;
  assign node_index_o   = res.node;
  assign shape_value_o  = res.shape;
  assign grad_x_o       = res.gx;
  assign grad_y_o       = res.gy;
  assign grad_z_o       = res.gz;
  assign jacobian_det_o = res.det;
  assign weight_o       = res.weight;
  assign singular_o     = res.singular;
  assign last_o         = res.last;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted element did not make the front busy");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("element queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("element queue read while empty");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && singular_o |-> grad_x_o == 0 && grad_y_o == 0 && grad_z_o == 0)
    else $error("singular result carries a nonzero gradient");

  a_centre_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && weight_o == WEIGHT_CTR |-> quad_index_o == 3'd0)
    else $error("centre point with nonzero point number");

endmodule

/* tb/tb_fem_element_shape_gradients.sv */
// testbench for the element shape gradient block: predicted results checked beat by beat
`timescale 1ns / 100ps

import fesg_pkg::*;

class shape_grad_scoreboard;
  fesg_res_t  expected_q[$];
  logic [1:0] dims_reg = DIMS_HEX;
  logic       reduced_reg = 1'b0;
  int         errors = 0;

  function automatic logic [63:0] round_shift(logic [63:0] v, int s);
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
    return round_shift(a * b, 30);
  endfunction

  // 1 when the node lies on the + side of the axis
  function automatic logic node_plus(int node, int axis);
    logic [2:0] nd3;
    nd3 = 3'(node);
    if (axis == 0) return nd3[0] ^ nd3[1];
    if (axis == 1) return nd3[1];
    return nd3[2];
  endfunction

  function automatic logic [31:0] gradient(logic neg, logic [63:0] e, logic [63:0] h, int nd);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    int ex;
    ex = FRAC_BITS - 13 - nd;
    num = e;
    den = h;
    if (ex >= 0) num = e << ex;
    else den = h << (-ex);
    q = (2 * num + den) / (2 * den);
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(0 - q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function void write_reg(fesg_cfg_idx_e idx, logic [1:0] data);
    if (idx == CFG_DIMS) dims_reg = data;
    else reduced_reg = data[0];
  endfunction

  function void note_element(logic [23:0] hx, logic [23:0] hy, logic [23:0] hz);
    logic [63:0] h [3];
    logic [63:0] f [3];
    logic [63:0] det, p, prod, sv, e;
    logic three, centre;
    int nd, npts, nnodes;
    fesg_res_t r;
    h[0] = 64'(hx); h[1] = 64'(hy); h[2] = 64'(hz);
    three = (dims_reg == DIMS_HEX);
    centre = three && reduced_reg;
    nd = three ? 3 : 2;
    nnodes = 1 << nd;
    npts = centre ? 1 : nnodes;
    if (three) begin
      p = h[0] * h[1];
      det = (p * (h[2] >> 12) + (64'd1 << 14) + ((p * (h[2] & 64'hFFF)) >> 12)) >> 15;
    end else begin
      det = round_shift(h[0] * h[1], 10);
    end
    det &= 64'hFFFF_FFFF_FFFF;
    for (int q = 0; q < npts; q++) begin
      for (int a = 0; a < nnodes; a++) begin
        for (int k = 0; k < 3; k++) begin
          if (centre || k >= nd) f[k] = ONE30;
          else if (node_plus(a, k) == q[k]) f[k] = ONE30 + GPT30;
          else f[k] = ONE30 - GPT30;
        end
        if (three) begin
          prod = q30_mul(f[0], f[1]) * f[2];
          sv = round_shift(prod, 63 - FRAC_BITS);
        end else begin
          prod = f[0] * f[1];
          sv = round_shift(prod, 62 - FRAC_BITS);
        end
        if (sv > 64'h1FFFF) sv = 64'h1FFFF;
        r = '0;
        r.quad = centre ? 3'd0 : 3'(q);
        r.node = 3'(a);
        r.shape = sv[16:0];
        r.det = det[47:0];
        r.weight = centre ? WEIGHT_CTR : WEIGHT_ONE;
        r.singular = (det == 0);
        r.last = (q == npts - 1) && (a == nnodes - 1);
        if (det != 0) begin
          for (int k = 0; k < nd; k++) begin
            if (three) e = q30_mul(f[(k + 1) % 3], f[(k + 2) % 3]);
            else e = f[1 - k];
            if (k == 0) r.gx = gradient(!node_plus(a, k), e, h[k], nd);
            else if (k == 1) r.gy = gradient(!node_plus(a, k), e, h[k], nd);
            else r.gz = gradient(!node_plus(a, k), e, h[k], nd);
          end
        end
        expected_q.push_back(r);
      end
    end
  endfunction

  function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(fesg_res_t act);
    fesg_res_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result beat with nothing expected");
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    compare_field("quad_index", 64'(exp_r.quad), 64'(act.quad));
    compare_field("node_index", 64'(exp_r.node), 64'(act.node));
    compare_field("shape_value", 64'(exp_r.shape), 64'(act.shape));
    compare_field("grad_x", 64'(exp_r.gx), 64'(act.gx));
    compare_field("grad_y", 64'(exp_r.gy), 64'(act.gy));
    compare_field("grad_z", 64'(exp_r.gz), 64'(act.gz));
    compare_field("jacobian_det", 64'(exp_r.det), 64'(act.det));
    compare_field("weight", 64'(exp_r.weight), 64'(act.weight));
    compare_field("singular", 64'(exp_r.singular), 64'(act.singular));
    compare_field("last", 64'(exp_r.last), 64'(act.last));
  endfunction
endclass

module tb_fem_element_shape_gradients;
  localparam int STALL_LIMIT = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [23:0]        elem_size_x_i = '0;
  logic [23:0]        elem_size_y_i = '0;
  logic [23:0]        elem_size_z_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = 1'b0;
  logic [1:0]         cfg_data_i = '0;
  logic               res_valid_o;
  logic [2:0]         quad_index_o;
  logic [2:0]         node_index_o;
  logic [16:0]        shape_value_o;
  logic signed [31:0] grad_x_o;
  logic signed [31:0] grad_y_o;
  logic signed [31:0] grad_z_o;
  logic [47:0]        jacobian_det_o;
  logic [3:0]         weight_o;
  logic               singular_o;
  logic               last_o;

  shape_grad_scoreboard sb = new();
  bit idle_on = 1'b1;
  int quiet_cycles = 0;

  fem_element_shape_gradients dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    fesg_res_t act;
    if (rst_ni && start_i && !busy_o)
      sb.note_element(elem_size_x_i, elem_size_y_i, elem_size_z_i);
    if (rst_ni && res_valid_o) begin
      act.quad = quad_index_o;
      act.node = node_index_o;
      act.shape = shape_value_o;
      act.gx = grad_x_o;
      act.gy = grad_y_o;
      act.gz = grad_z_o;
      act.det = jacobian_det_o;
      act.weight = weight_o;
      act.singular = singular_o;
      act.last = last_o;
      sb.check_result(act);
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_cfg(fesg_cfg_idx_e idx, logic [1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // start is left high so back-to-back elements are taken as soon as the front is idle again
  task automatic send_element(logic [23:0] hx, logic [23:0] hy, logic [23:0] hz);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    elem_size_x_i <= hx;
    elem_size_y_i <= hy;
    elem_size_z_i <= hz;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_size();
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom_range(1, 16));
      3, 4: return 24'($urandom_range(24'h8000, 24'h4_0000));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [1:0] dset [8];
    logic [1:0] rset [8];
    dset = '{2'd3, 2'd3, 2'd2, 2'd2, 2'd0, 2'd1, 2'd3, 2'd3};
    rset = '{2'd0, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, singular boxes, saturating gradients at reset settings
    send_element(24'h01_0000, 24'h01_0000, 24'h01_0000);
    send_element(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    send_element(24'd0, 24'hFF_FFFF, 24'hFF_FFFF);
    send_element(24'hFF_FFFF, 24'd0, 24'h01_0000);
    send_element(24'h01_0000, 24'h01_0000, 24'd0);
    send_element(24'd1, 24'd1, 24'd1);
    send_element(24'd1, 24'hFF_FFFF, 24'd2);
    send_element(24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA);
    send_element(24'h55_5555, 24'hAA_AAAA, 24'h55_5555);
    send_element(24'd0, 24'd0, 24'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(CFG_DIMS, dset[ph]);
      write_cfg(CFG_REDUCED, rset[ph]);
      if (ph == 7) idle_on = 1'b0;
      // each setting gets a few extreme boxes before random ones
      send_element(24'd1, 24'hFF_FFFF, 24'd1);
      send_element(24'hFF_FFFF, 24'd1, 24'hFF_FFFF);
      send_element(24'd0, 24'h01_0000, 24'h02_0000);
      for (int i = 0; i < 31; i++)
        send_element(rand_size(), rand_size(), rand_size());
      drain();
    end

    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
